/* rtl/inverted_word_index_builder_defines.svh */
// Assertion macros shared by the inverted word index builder files.
`ifndef INVERTED_WORD_INDEX_BUILDER_DEFINES_SVH
`define INVERTED_WORD_INDEX_BUILDER_DEFINES_SVH

// Condition that must hold at every clock edge outside reset.
`define IWIB_ASSERT_ALWAYS(label, clk, rst, cond, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (cond)) else $error(msg);

// Consequence that must hold in the same cycle as the trigger.
`define IWIB_ASSERT_IMPL(label, clk, rst, ante, cons, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) else $error(msg);

// Consequence that must hold in the cycle after the trigger.
`define IWIB_ASSERT_NEXT(label, clk, rst, ante, cons, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) else $error(msg);

`endif

/* rtl/iwib_pkg.sv */
// Shared types, codes and helper functions of the inverted word index builder.
package iwib_pkg;

   localparam int OP_W         = 3;
   localparam int STATUS_W     = 3;
   localparam int ID_W         = 9;
   localparam int WORD_INDEX_W = 11;

   typedef enum logic [OP_W-1:0] {
      OP_CONTENT = 3'd0,
      OP_EOF     = 3'd1,
      OP_QBYTE   = 3'd2,
      OP_QEND    = 3'd3,
      OP_CLEAR   = 3'd4
   } op_type;

   typedef enum logic [STATUS_W-1:0] {
      ST_SHORT     = 3'd0,
      ST_TABLEFULL = 3'd1,
      ST_ADDED     = 3'd2,
      ST_LISTED    = 3'd3,
      ST_LISTFULL  = 3'd4,
      ST_HIT       = 3'd5,
      ST_MISS      = 3'd6
   } status_type;

   // Folds A-Z onto a-z, leaves every other byte alone.
   function automatic logic [7:0] lower_byte(input logic [7:0] c);
      logic [7:0] r;
      r = c;
      if (c >= 8'h41 && c <= 8'h5A) begin
         r = c + 8'd32;
      end
      return r;
   endfunction

   // Letters, digits and underscore make up words.
   function automatic logic is_word_byte(input logic [7:0] c);
      return (c >= 8'h61 && c <= 8'h7A) || (c >= 8'h41 && c <= 8'h5A) ||
             (c >= 8'h30 && c <= 8'h39) || (c == 8'h5F);
   endfunction

endpackage

/* rtl/iwib_if.sv */
// Valid/ready channel interfaces for request and response words.
interface iwib_req_if
   import iwib_pkg::*;
   ();
   logic              valid;
   logic              ready;
   logic [OP_W-1:0]   op;
   logic [7:0]        byte_req;
   logic [ID_W-1:0]   file_id;

   modport source (output valid, op, byte_req, file_id, input ready);
   modport sink   (input valid, op, byte_req, file_id, output ready);
endinterface

interface iwib_rsp_if
   import iwib_pkg::*;
   ();
   logic                    valid;
   logic                    ready;
   logic [STATUS_W-1:0]     status;
   logic [WORD_INDEX_W-1:0] word_index;
   logic                    new_word;
   logic [ID_W-1:0]         hit_file;
   logic                    last;

   modport source (output valid, status, word_index, new_word, hit_file, last, input ready);
   modport sink   (input valid, status, word_index, new_word, hit_file, last, output ready);
endinterface

/* rtl/iwib_ram.sv */
// Generic single-port-write, single-port-read RAM with registered read data.
module iwib_ram #(
   parameter int WIDTH = 8,
   parameter int DEPTH = 16,
   localparam int ADDR_W = $clog2(DEPTH)
) (
   input  logic              clock,
   input  logic              wr_en,
   input  logic [ADDR_W-1:0] wr_addr,
   input  logic [WIDTH-1:0]  wr_data,
   input  logic [ADDR_W-1:0] rd_addr,
   output logic [WIDTH-1:0]  rd_data
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
      rd_data_ff <= mem_ff[rd_addr];
   end

   assign rd_data = rd_data_ff;

endmodule

/* rtl/inverted_word_index_builder.sv */
// Top level of the inverted word index builder: word gathering, table search and posting lists.
//
// Usage: request words arrive on req_ch (op, byte_req, file_id) under valid/ready.
// Content bytes build a word, and a separator byte, an end-of-file word or an
// over-long word closes it. Each closed word yields one response word on rsp_ch
// (status, word_index, new_word, last). Query bytes build a query; a query-end
// word yields the posting list, one response word per file id, or one miss word.
// Byte, clear and unused-op words are taken without leaving S_IDLE and give no response.
// A closed word or a query end searches the word table linearly: for each stored word,
// one read of the word memory (S_SCAN_RD) and one compare (S_SCAN_CMP). A match then
// reads the posting memory (S_POST_RD) and checks or updates it (S_POST_UPD); a new
// word is written in S_NEW. S_EMIT registers the single response word and returns to
// S_IDLE, where the input is ready again. A hit instead streams from S_STREAM, one
// file id per cycle while the receiver takes them, and the input is ready after the last.
// The word table and the posting lists each live in one synchronous RAM; only
// one access is used at a time, and a read made while its entry is written is never used.
// Reset (synchronous, active high) empties the table through its fill count, drops
// any gathered word or query and clears the response register; no memory sweep.
// While the receiver stalls, the response register holds its word; byte words are
// still accepted, but an item that produces a response waits for the register.
module inverted_word_index_builder
   import iwib_pkg::*;
#(
   parameter int MAX_WORDS    = 2048,
   parameter int WORD_LEN     = 32,
   parameter int MAX_POSTINGS = 16
) (
   input  logic clock,
   input  logic reset,
   iwib_req_if.sink   req_ch,
   iwib_rsp_if.source rsp_ch
);

   `include "inverted_word_index_builder_defines.svh"

   // A word holds at most WORD_LEN - 1 characters.
   localparam int NCH     = WORD_LEN - 1;
   localparam int LEN_W   = $clog2(WORD_LEN);
   localparam int SLOT_W  = $clog2(MAX_WORDS);
   localparam int USED_W  = $clog2(MAX_WORDS + 1);
   localparam int PCNT_W  = $clog2(MAX_POSTINGS + 1);
   localparam int PIDX_W  = (MAX_POSTINGS > 1) ? $clog2(MAX_POSTINGS) : 1;
   localparam int CHARS_W = NCH * 8;
   localparam int WROW_W  = CHARS_W + LEN_W;
   localparam int IDS_W   = MAX_POSTINGS * ID_W;
   localparam int PROW_W  = IDS_W + PCNT_W;

   typedef enum logic [2:0] {
      S_IDLE,
      S_SCAN_RD,
      S_SCAN_CMP,
      S_NEW,
      S_POST_RD,
      S_POST_UPD,
      S_EMIT,
      S_STREAM
   } state_type;

   typedef logic [NCH-1:0][7:0]            chars_type;
   typedef logic [MAX_POSTINGS-1:0][ID_W-1:0] ids_type;

   // Control state.
   state_type state_ff, state_in;
   logic [LEN_W-1:0]  cur_len_ff, cur_len_in;
   logic [LEN_W-1:0]  q_len_ff, q_len_in;
   logic [USED_W-1:0] used_ff, used_in;
   logic              rsp_valid_ff, rsp_valid_in;

   // Working registers and payload.
   chars_type         cur_chars_ff, cur_chars_in;
   chars_type         q_chars_ff, q_chars_in;
   logic [USED_W-1:0] scan_ff, scan_in;
   logic [SLOT_W-1:0] slot_ff, slot_in;
   logic [LEN_W-1:0]  key_len_ff, key_len_in;
   logic              query_mode_ff, query_mode_in;
   logic [ID_W-1:0]   fid_ff, fid_in;
   status_type        pend_status_ff, pend_status_in;
   logic [WORD_INDEX_W-1:0] pend_index_ff, pend_index_in;
   logic              pend_new_ff, pend_new_in;
   ids_type           ids_ff, ids_in;
   logic [PCNT_W-1:0] cnt_ff, cnt_in;
   logic [PCNT_W-1:0] sidx_ff, sidx_in;
   logic [STATUS_W-1:0]     rsp_status_ff, rsp_status_in;
   logic [WORD_INDEX_W-1:0] rsp_index_ff, rsp_index_in;
   logic                    rsp_new_ff, rsp_new_in;
   logic [ID_W-1:0]         rsp_hit_ff, rsp_hit_in;
   logic                    rsp_last_ff, rsp_last_in;

   // Memory ports.
   logic              wmem_wr_en;
   logic [WROW_W-1:0] wmem_wr_data;
   logic [WROW_W-1:0] wmem_rd_data;
   logic              pmem_wr_en;
   logic [PROW_W-1:0] pmem_wr_data;
   logic [PROW_W-1:0] pmem_rd_data;

   // Decoded memory rows and handshake helpers.
   chars_type         row_chars;
   logic [LEN_W-1:0]  row_len;
   chars_type         key_chars;
   logic              word_match;
   ids_type           row_ids;
   ids_type           upd_ids;
   logic [PCNT_W-1:0] row_cnt;
   logic              id_seen;
   logic              accept;
   logic              out_free;
   logic [7:0]        in_byte;

   iwib_ram #(.WIDTH(WROW_W), .DEPTH(MAX_WORDS)) u_word_ram (
      .clock   (clock),
      .wr_en   (wmem_wr_en),
      .wr_addr (slot_ff),
      .wr_data (wmem_wr_data),
      .rd_addr (scan_ff[SLOT_W-1:0]),
      .rd_data (wmem_rd_data)
   );

   iwib_ram #(.WIDTH(PROW_W), .DEPTH(MAX_WORDS)) u_post_ram (
      .clock   (clock),
      .wr_en   (pmem_wr_en),
      .wr_addr (slot_ff),
      .wr_data (pmem_wr_data),
      .rd_addr (slot_ff),
      .rd_data (pmem_rd_data)
   );

   assign accept       = req_ch.valid && req_ch.ready;
   assign req_ch.ready = (state_ff == S_IDLE);
   assign out_free     = !rsp_valid_ff || rsp_ch.ready;
   assign in_byte      = req_ch.byte_req;

   assign row_chars = wmem_rd_data[WROW_W-1 -: CHARS_W];
   assign row_len   = wmem_rd_data[LEN_W-1:0];
   assign row_ids   = pmem_rd_data[PROW_W-1 -: IDS_W];
   assign row_cnt   = pmem_rd_data[PCNT_W-1:0];
   assign key_chars = query_mode_ff ? q_chars_ff : cur_chars_ff;

   // Bytes past the key length take no part in the compare.
   always_comb begin
      word_match = (row_len == key_len_ff);
      for (int i = 0; i < NCH; i++) begin
         if (LEN_W'(i) < key_len_ff && row_chars[i] != key_chars[i]) begin
            word_match = 1'b0;
         end
      end
   end

   // Duplicate check over the valid part of the posting list, plus the appended row.
   always_comb begin
      id_seen = 1'b0;
      upd_ids = row_ids;
      for (int j = 0; j < MAX_POSTINGS; j++) begin
         if (PCNT_W'(j) < row_cnt && row_ids[j] == fid_ff) begin
            id_seen = 1'b1;
         end
      end
      upd_ids[row_cnt[PIDX_W-1:0]] = fid_ff;
   end

   always_comb begin
      state_in       = state_ff;
      cur_len_in     = cur_len_ff;
      q_len_in       = q_len_ff;
      used_in        = used_ff;
      cur_chars_in   = cur_chars_ff;
      q_chars_in     = q_chars_ff;
      scan_in        = scan_ff;
      slot_in        = slot_ff;
      key_len_in     = key_len_ff;
      query_mode_in  = query_mode_ff;
      fid_in         = fid_ff;
      pend_status_in = pend_status_ff;
      pend_index_in  = pend_index_ff;
      pend_new_in    = pend_new_ff;
      ids_in         = ids_ff;
      cnt_in         = cnt_ff;
      sidx_in        = sidx_ff;
      rsp_valid_in   = rsp_valid_ff && !rsp_ch.ready;
      rsp_status_in  = rsp_status_ff;
      rsp_index_in   = rsp_index_ff;
      rsp_new_in     = rsp_new_ff;
      rsp_hit_in     = rsp_hit_ff;
      rsp_last_in    = rsp_last_ff;
      wmem_wr_en     = 1'b0;
      wmem_wr_data   = {cur_chars_ff, key_len_ff};
      pmem_wr_en     = 1'b0;
      pmem_wr_data   = {upd_ids, row_cnt + PCNT_W'(1)};

      unique case (state_ff)
         S_IDLE: begin
            if (accept) begin
               case (req_ch.op) inside
                  OP_CONTENT, OP_EOF: begin
                     if (req_ch.op == OP_CONTENT && is_word_byte(in_byte) &&
                         cur_len_ff != LEN_W'(NCH)) begin
                        // Characters are folded to lower case as they arrive.
                        cur_chars_in[cur_len_ff] = lower_byte(in_byte);
                        cur_len_in = cur_len_ff + LEN_W'(1);
                     end else if (cur_len_ff != '0) begin
                        cur_len_in    = '0;
                        key_len_in    = cur_len_ff;
                        fid_in        = req_ch.file_id;
                        query_mode_in = 1'b0;
                        scan_in       = '0;
                        if (cur_len_ff < LEN_W'(2)) begin
                           pend_status_in = ST_SHORT;
                           pend_index_in  = '0;
                           pend_new_in    = 1'b0;
                           state_in       = S_EMIT;
                        end else begin
                           state_in = S_SCAN_RD;
                        end
                     end
                  end
                  OP_QBYTE: begin
                     if (q_len_ff != LEN_W'(NCH)) begin
                        q_chars_in[q_len_ff] = lower_byte(in_byte);
                        q_len_in = q_len_ff + LEN_W'(1);
                     end
                  end
                  OP_QEND: begin
                     key_len_in    = q_len_ff;
                     q_len_in      = '0;
                     query_mode_in = 1'b1;
                     scan_in       = '0;
                     state_in      = S_SCAN_RD;
                  end
                  OP_CLEAR: begin
                     used_in = '0;
                  end
                  default: begin
                  end
               endcase
            end
         end
         S_SCAN_RD: begin
            if (scan_ff == used_ff) begin
               pend_index_in = '0;
               pend_new_in   = 1'b0;
               if (query_mode_ff) begin
                  pend_status_in = ST_MISS;
                  state_in       = S_EMIT;
               end else if (used_ff == USED_W'(MAX_WORDS)) begin
                  pend_status_in = ST_TABLEFULL;
                  state_in       = S_EMIT;
               end else begin
                  slot_in  = used_ff[SLOT_W-1:0];
                  state_in = S_NEW;
               end
            end else begin
               state_in = S_SCAN_CMP;
            end
         end
         S_SCAN_CMP: begin
            if (word_match) begin
               slot_in  = scan_ff[SLOT_W-1:0];
               state_in = S_POST_RD;
            end else begin
               scan_in  = scan_ff + USED_W'(1);
               state_in = S_SCAN_RD;
            end
         end
         S_NEW: begin
            // A new word starts its posting list with the closing file id.
            wmem_wr_en       = 1'b1;
            pmem_wr_en       = 1'b1;
            pmem_wr_data     = '0;
            pmem_wr_data[PROW_W-1 -: IDS_W] = IDS_W'(fid_ff);
            pmem_wr_data[PCNT_W-1:0]        = PCNT_W'(1);
            used_in          = used_ff + USED_W'(1);
            pend_status_in   = ST_ADDED;
            pend_index_in    = WORD_INDEX_W'(slot_ff);
            pend_new_in      = 1'b1;
            state_in         = S_EMIT;
         end
         S_POST_RD: begin
            state_in = S_POST_UPD;
         end
         S_POST_UPD: begin
            pend_index_in = WORD_INDEX_W'(slot_ff);
            pend_new_in   = 1'b0;
            if (query_mode_ff) begin
               if (row_cnt == '0) begin
                  pend_status_in = ST_MISS;
                  pend_index_in  = '0;
                  state_in       = S_EMIT;
               end else begin
                  ids_in   = row_ids;
                  cnt_in   = row_cnt;
                  sidx_in  = '0;
                  state_in = S_STREAM;
               end
            end else begin
               if (id_seen) begin
                  pend_status_in = ST_LISTED;
               end else if (row_cnt >= PCNT_W'(MAX_POSTINGS)) begin
                  pend_status_in = ST_LISTFULL;
               end else begin
                  pmem_wr_en     = 1'b1;
                  pend_status_in = ST_ADDED;
               end
               state_in = S_EMIT;
            end
         end
         S_EMIT: begin
            if (out_free) begin
               rsp_valid_in  = 1'b1;
               rsp_status_in = pend_status_ff;
               rsp_index_in  = pend_index_ff;
               rsp_new_in    = pend_new_ff;
               rsp_hit_in    = '0;
               rsp_last_in   = 1'b1;
               state_in      = S_IDLE;
            end
         end
         S_STREAM: begin
            if (out_free) begin
               rsp_valid_in  = 1'b1;
               rsp_status_in = ST_HIT;
               rsp_index_in  = WORD_INDEX_W'(slot_ff);
               rsp_new_in    = 1'b0;
               rsp_hit_in    = ids_ff[sidx_ff[PIDX_W-1:0]];
               rsp_last_in   = (sidx_ff + PCNT_W'(1)) == cnt_ff;
               sidx_in       = sidx_ff + PCNT_W'(1);
               if ((sidx_ff + PCNT_W'(1)) == cnt_ff) begin
                  state_in = S_IDLE;
               end
            end
         end
         default: begin
            state_in = S_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= S_IDLE;
         cur_len_ff   <= '0;
         q_len_ff     <= '0;
         used_ff      <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         cur_len_ff   <= cur_len_in;
         q_len_ff     <= q_len_in;
         used_ff      <= used_in;
         rsp_valid_ff <= rsp_valid_in;
      end
      cur_chars_ff   <= cur_chars_in;
      q_chars_ff     <= q_chars_in;
      scan_ff        <= scan_in;
      slot_ff        <= slot_in;
      key_len_ff     <= key_len_in;
      query_mode_ff  <= query_mode_in;
      fid_ff         <= fid_in;
      pend_status_ff <= pend_status_in;
      pend_index_ff  <= pend_index_in;
      pend_new_ff    <= pend_new_in;
      ids_ff         <= ids_in;
      cnt_ff         <= cnt_in;
      sidx_ff        <= sidx_in;
      rsp_status_ff  <= rsp_status_in;
      rsp_index_ff   <= rsp_index_in;
      rsp_new_ff     <= rsp_new_in;
      rsp_hit_ff     <= rsp_hit_in;
      rsp_last_ff    <= rsp_last_in;
   end

   assign rsp_ch.valid      = rsp_valid_ff;
   assign rsp_ch.status     = rsp_status_ff;
   assign rsp_ch.word_index = rsp_index_ff;
   assign rsp_ch.new_word   = rsp_new_ff;
   assign rsp_ch.hit_file   = rsp_hit_ff;
   assign rsp_ch.last       = rsp_last_ff;

   // The fill count never passes the table size.
   `IWIB_ASSERT_ALWAYS(a_used_bound, clock, reset, used_ff <= USED_W'(MAX_WORDS), "word table count overflow")
   // Appending a word advances the fill count by exactly one.
   `IWIB_ASSERT_NEXT(a_append_count, clock, reset, state_ff == S_NEW, used_ff == $past(used_ff) + USED_W'(1), "append did not advance fill count")
   // A posting stream never reads past the list length.
   `IWIB_ASSERT_IMPL(a_stream_range, clock, reset, state_ff == S_STREAM, sidx_ff < cnt_ff, "posting stream index out of range")

endmodule

/* tb/sv/tb_inverted_word_index_builder.sv */
// Self-checking testbench of the inverted word index builder with its own index model.
`timescale 1ns / 1ps

module tb_inverted_word_index_builder;
   import iwib_pkg::*;

   localparam int TBL_WORDS   = 2048;
   localparam int TBL_LEN     = 32;
   localparam int TBL_IDS     = 16;
   localparam int CYCLE_LIMIT = 2000000;

   // One response word as the index model expects it.
   typedef struct {
      status_type              st;
      logic [WORD_INDEX_W-1:0] idx;
      logic                    fresh;
      logic [ID_W-1:0]         hit;
      logic                    last;
   } index_result_type;

   logic clock;
   logic reset;

   iwib_req_if req ();
   iwib_rsp_if rsp ();

   inverted_word_index_builder DUT (
      .clock  (clock),
      .reset  (reset),
      .req_ch (req),
      .rsp_ch (rsp)
   );

   // The clock runs with a 12 ns period, high and low for half of it each.
   always begin
      clock = 1'b1;
      #6;
      clock = 1'b0;
      #6;
   end

   // Private copy of the word table, the posting lists and the words being gathered.
   logic [7:0]      tbl_chars   [TBL_WORDS][TBL_LEN];
   int              tbl_len     [TBL_WORDS];
   logic [ID_W-1:0] tbl_ids     [TBL_WORDS][TBL_IDS];
   int              tbl_count   [TBL_WORDS];
   int              tbl_used;
   logic [7:0]      gather_word [TBL_LEN];
   int              gather_len;
   logic [7:0]      query_buf   [TBL_LEN];
   int              query_len;

   // Response words that the model has predicted and the block has not yet sent.
   index_result_type pending_results[$];

   int  failures;
   int  cycle_count;
   bit  quiet_sender;     // When set, the sender never idles between words.
   bit  hold_request;     // Set by a test to make the receiver stall for a long time.
   int  hold_left;

   string vocab[8] = '{"alpha", "beta", "gamma_1", "x9", "delta", "ab", "zz_top", "q0"};

   // True for the bytes that belong to a word: letters, digits and underscore.
   function automatic bit in_word(input logic [7:0] c);
      return (c >= "a" && c <= "z") || (c >= "A" && c <= "Z") ||
             (c >= "0" && c <= "9") || c == "_";
   endfunction

   function automatic logic [7:0] fold_case(input logic [7:0] c);
      return (c >= "A" && c <= "Z") ? c + 8'd32 : c;
   endfunction

   // Linear search over the filled part of the table; -1 when the word is absent.
   function automatic int find_slot(input logic [7:0] w[TBL_LEN], input int len);
      int i;
      int k;
      bit same;
      for (i = 0; i < tbl_used; i++) begin
         if (tbl_len[i] == len) begin
            same = 1'b1;
            for (k = 0; k < len; k++) begin
               if (tbl_chars[i][k] != w[k]) begin
                  same = 1'b0;
               end
            end
            if (same) begin
               return i;
            end
         end
      end
      return -1;
   endfunction

   task automatic push_result(input status_type st, input int idx, input bit fresh,
                              input logic [ID_W-1:0] hit, input bit last);
      index_result_type r;
      r.st    = st;
      r.idx   = idx[WORD_INDEX_W-1:0];
      r.fresh = fresh;
      r.hit   = hit;
      r.last  = last;
      pending_results.push_back(r);
   endtask

   // A closed word is folded to lower case, looked up or appended, and the file id is
   // entered in its posting list. An empty word gives no response at all.
   task automatic close_gathered(input logic [ID_W-1:0] fid);
      int len;
      int slot;
      int i;
      bit fresh;
      len   = gather_len;
      fresh = 1'b0;
      if (len == 0) begin
         return;
      end
      gather_len = 0;
      for (i = 0; i < len; i++) begin
         gather_word[i] = fold_case(gather_word[i]);
      end
      if (len < 2) begin
         push_result(ST_SHORT, 0, 1'b0, '0, 1'b1);
         return;
      end
      slot = find_slot(gather_word, len);
      if (slot < 0) begin
         if (tbl_used >= TBL_WORDS) begin
            push_result(ST_TABLEFULL, 0, 1'b0, '0, 1'b1);
            return;
         end
         slot = tbl_used;
         tbl_used++;
         for (i = 0; i < len; i++) begin
            tbl_chars[slot][i] = gather_word[i];
         end
         tbl_len[slot]   = len;
         tbl_count[slot] = 0;
         fresh = 1'b1;
      end
      for (i = 0; i < tbl_count[slot]; i++) begin
         if (tbl_ids[slot][i] == fid) begin
            push_result(ST_LISTED, slot, fresh, '0, 1'b1);
            return;
         end
      end
      if (tbl_count[slot] >= TBL_IDS) begin
         push_result(ST_LISTFULL, slot, fresh, '0, 1'b1);
         return;
      end
      tbl_ids[slot][tbl_count[slot]] = fid;
      tbl_count[slot]++;
      push_result(ST_ADDED, slot, fresh, '0, 1'b1);
   endtask

   // Works out the response words that one accepted request word causes.
   task automatic index_model_step(input logic [OP_W-1:0] op, input logic [7:0] b,
                                   input logic [ID_W-1:0] fid);
      int slot;
      int len;
      int j;
      case (op)
         OP_CONTENT: begin
            if (in_word(b) && gather_len < TBL_LEN - 1) begin
               gather_word[gather_len] = b;
               gather_len++;
            end else begin
               close_gathered(fid);
            end
         end
         OP_EOF: begin
            close_gathered(fid);
         end
         OP_QBYTE: begin
            if (query_len < TBL_LEN - 1) begin
               query_buf[query_len] = fold_case(b);
               query_len++;
            end
         end
         OP_QEND: begin
            len       = query_len;
            query_len = 0;
            slot      = find_slot(query_buf, len);
            if (slot < 0 || tbl_count[slot] == 0) begin
               push_result(ST_MISS, 0, 1'b0, '0, 1'b1);
            end else begin
               for (j = 0; j < tbl_count[slot]; j++) begin
                  push_result(ST_HIT, slot, 1'b0, tbl_ids[slot][j],
                              j == tbl_count[slot] - 1);
               end
            end
         end
         OP_CLEAR: begin
            tbl_used = 0;
         end
         default: begin
            // Unused op codes leave everything as it is.
         end
      endcase
   endtask

   // Mostly no gap or a short one, now and then a long one.
   function automatic int pick_gap();
      int r;
      r = $urandom_range(0, 99);
      if (r < 60) begin
         return 0;
      end else if (r < 90) begin
         return $urandom_range(1, 3);
      end
      return $urandom_range(10, 40);
   endfunction

   // Offers one request word until it is taken, feeds it to the model, then may idle.
   // Valid is only raised when it is low, so a word that follows directly never sees
   // valid lowered and raised in the same time step.
   task automatic send_word(input logic [OP_W-1:0] op, input logic [7:0] b,
                            input logic [ID_W-1:0] fid);
      int gap;
      if (!req.valid) begin
         req.valid <= 1'b1;
      end
      req.op       <= op;
      req.byte_req <= b;
      req.file_id  <= fid;
      do begin
         @(posedge clock);
      end while (!req.ready);
      index_model_step(op, b, fid);
      gap = quiet_sender ? 0 : pick_gap();
      if (gap > 0) begin
         req.valid <= 1'b0;
         repeat (gap) @(posedge clock);
      end
   endtask

   task automatic send_text(input string s, input logic [OP_W-1:0] op,
                            input logic [ID_W-1:0] fid);
      int i;
      for (i = 0; i < s.len(); i++) begin
         send_word(op, s[i], fid);
      end
   endtask

   // Returns a vocabulary word with each letter in random case.
   function automatic string mixed_case(input string s);
      string r;
      int i;
      r = s;
      for (i = 0; i < r.len(); i++) begin
         if (r[i] >= "a" && r[i] <= "z" && $urandom_range(0, 1)) begin
            r[i] = r[i] - 8'd32;
         end
      end
      return r;
   endfunction

   // Picks a byte that closes a word.
   function automatic logic [7:0] separator_byte();
      logic [7:0] c;
      do begin
         c = 8'($urandom_range(0, 255));
      end while (in_word(c));
      return c;
   endfunction

   // Stops offering, then waits until every predicted response has arrived,
   // with some margin after it.
   task automatic drain();
      req.valid <= 1'b0;
      while (pending_results.size() != 0) begin
         @(posedge clock);
      end
      repeat (20) @(posedge clock);
   endtask

   // Extremes of the fields, every op and the special cases, checked one by one.
   task automatic test_directed();
      int i;
      send_text("A ", OP_CONTENT, 9'd0);            // Single character word is too short.
      send_word(OP_CONTENT, 8'h20, 9'd0);            // Closing with nothing gathered.
      send_text("Hello_9", OP_CONTENT, 9'd3);
      send_word(OP_EOF, 8'hFF, 9'd511);              // End of file closes with its own id.
      send_text("hELLO_9,", OP_CONTENT, 9'd511);     // Same word, same id: already listed.
      for (i = 0; i < TBL_LEN - 1; i++) begin
         send_word(OP_CONTENT, "Z", 9'd7);
      end
      send_word(OP_CONTENT, "q", 9'd8);              // Overflow closes the word, q is dropped.
      send_word(OP_EOF, 8'h00, 9'd8);
      send_text("HELLO_9", OP_QBYTE, 9'd0);
      send_word(OP_QEND, 8'h00, 9'd0);               // Hit with a single id.
      send_word(OP_QEND, 8'h00, 9'd0);               // Empty query misses.
      send_word(OP_QBYTE, 8'hFF, 9'd0);
      send_word(OP_QBYTE, 8'h80, 9'd0);
      send_word(OP_QEND, 8'h00, 9'd0);               // Bytes no word can hold: miss.
      for (i = 0; i < TBL_LEN + 2; i++) begin
         send_word(OP_QBYTE, "z", 9'd0);             // Query overflow drops the tail.
      end
      send_word(OP_QEND, 8'h00, 9'd0);
      send_word(3'd5, 8'h41, 9'd1);                  // Unused op codes do nothing.
      send_word(3'd7, 8'h41, 9'd1);
      send_text("ab", OP_CONTENT, 9'd2);
      send_word(OP_CLEAR, 8'h00, 9'd0);              // The word being gathered survives.
      send_word(OP_EOF, 8'h00, 9'd2);
      drain();
   endtask

   // Seventeen files share one word, so its posting list fills up, then streams 16 ids.
   task automatic test_list_full();
      int i;
      send_word(OP_CLEAR, 8'h00, 9'd0);
      for (i = 0; i < TBL_IDS + 1; i++) begin
         send_text("Ab.", OP_CONTENT, ID_W'(i * 30));
      end
      send_text("ab", OP_QBYTE, 9'd0);
      send_word(OP_QEND, 8'h00, 9'd0);
      drain();
   endtask

   // The receiver stalls for a long stretch while the sender keeps offering queries
   // that each stream a full posting list, so the block backs up into its input.
   task automatic test_backpressure();
      int i;
      quiet_sender = 1'b1;
      hold_request = 1'b1;
      for (i = 0; i < 6; i++) begin
         send_text("ab", OP_QBYTE, 9'd0);
         send_word(OP_QEND, 8'h00, 9'd0);
      end
      quiet_sender = 1'b0;
      drain();
   endtask

   // Mostly well-formed text and queries over a small vocabulary, with some noise.
   task automatic test_random();
      int n;
      int r;
      string s;
      n = 0;
      while (n < 40) begin
         r = $urandom_range(0, 99);
         quiet_sender = ($urandom_range(0, 9) == 0);
         if (r < 55) begin
            s = mixed_case(vocab[$urandom_range(0, 7)]);
            send_text(s, OP_CONTENT, ID_W'($urandom_range(0, 511)));
            if ($urandom_range(0, 3) == 0) begin
               send_word(OP_EOF, 8'($urandom_range(0, 255)), ID_W'($urandom_range(0, 511)));
            end else begin
               send_word(OP_CONTENT, separator_byte(), ID_W'($urandom_range(0, 511)));
            end
            n += s.len() + 1;
         end else if (r < 75) begin
            s = mixed_case(vocab[$urandom_range(0, 7)]);
            send_text(s, OP_QBYTE, ID_W'($urandom_range(0, 511)));
            send_word(OP_QEND, 8'($urandom_range(0, 255)), ID_W'($urandom_range(0, 511)));
            n += s.len() + 1;
         end else if (r < 98) begin
            send_word(OP_W'($urandom_range(0, 7)), 8'($urandom_range(0, 255)),
                      ID_W'($urandom_range(0, 511)));
            n++;
         end else begin
            send_word(OP_CLEAR, 8'($urandom_range(0, 255)), ID_W'($urandom_range(0, 511)));
            n++;
         end
      end
      quiet_sender = 1'b0;
      drain();
   endtask

   // Receiver: random stalls, plus one long hold-off when a test asks for it.
   always @(posedge clock) begin
      if (hold_request && hold_left == 0) begin
         hold_request <= 1'b0;
         hold_left    <= 400;
         rsp.ready    <= 1'b0;
      end else if (hold_left > 0) begin
         hold_left <= hold_left - 1;
         rsp.ready <= (hold_left == 1);
      end else if (quiet_sender) begin
         rsp.ready <= 1'b1;
      end else begin
         rsp.ready <= (pick_gap() == 0);
      end
   end

   // Compares every accepted response word with the oldest prediction.
   always @(posedge clock) begin
      index_result_type e;
      if (!reset && rsp.valid && rsp.ready) begin
         if (pending_results.size() == 0) begin
            $display("%0t: unexpected response status %0d index %0d", $realtime,
                     rsp.status, rsp.word_index);
            failures++;
         end else begin
            e = pending_results.pop_front();
            if (rsp.status !== e.st || rsp.word_index !== e.idx ||
                rsp.new_word !== e.fresh || rsp.hit_file !== e.hit || rsp.last !== e.last) begin
               $display("%0t: mismatch expected st %0d idx %0d new %0d file %0d last %0d",
                        $realtime, e.st, e.idx, e.fresh, e.hit, e.last);
               $display("%0t:          actual   st %0d idx %0d new %0d file %0d last %0d",
                        $realtime, rsp.status, rsp.word_index, rsp.new_word,
                        rsp.hit_file, rsp.last);
               failures++;
            end
         end
      end
   end

   // Watchdog over the whole run.
   always @(posedge clock) begin
      cycle_count <= cycle_count + 1;
      if (cycle_count > CYCLE_LIMIT) begin
         $display("Verification failed");
         $finish;
      end
   end

   initial begin
      req.valid    = 1'b0;
      req.op       = OP_CONTENT;
      req.byte_req = 8'h00;
      req.file_id  = '0;
      rsp.ready    = 1'b0;
      reset        = 1'b1;
      failures     = 0;
      cycle_count  = 0;
      quiet_sender = 1'b0;
      hold_request = 1'b0;
      hold_left    = 0;
      tbl_used     = 0;
      gather_len   = 0;
      query_len    = 0;
      repeat (8) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      test_directed();
      test_list_full();
      test_backpressure();
      test_random();

      req.valid <= 1'b0;
      if (pending_results.size() != 0) begin
         failures++;
      end
      if (failures == 0) begin
         $display("Verification passed");
      end else begin
         $display("Verification failed");
      end
      $finish;
   end

endmodule
